[hw/rtl/crtc_pkg.sv]
// Package: commands, register selectors, time-of-count type and small reducers for the RTC.
`default_nettype none

package crtc_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_e;

  localparam logic [3:0] REG_SEC      = 4'd8;
  localparam logic [3:0] REG_MIN      = 4'd9;
  localparam logic [3:0] REG_HOUR     = 4'd10;
  localparam logic [3:0] REG_DAY_LOW  = 4'd11;
  localparam logic [3:0] REG_DAY_HIGH = 4'd12;

  localparam int unsigned SecPerMin   = 60;
  localparam int unsigned MinPerHour  = 60;
  localparam int unsigned HourPerDay  = 24;
  localparam int unsigned DaysWidth   = 16;

  typedef struct packed {
    logic [DaysWidth-1:0] days;
    logic [4:0]           hours;
    logic [5:0]           mins;
    logic [5:0]           secs;
  } rtc_time_t;

  // 2^32 seconds as days, hours, minutes, seconds
  localparam rtc_time_t WrapTime = '{
    days:  16'd49710,
    hours: 5'd6,
    mins:  6'd28,
    secs:  6'd16
  };

  function automatic logic [5:0] mod60(input logic [7:0] d);
    logic [7:0] r;
    r = d;
    for (int k = 1; k <= 4; k++) begin
      if (d >= 8'(k * SecPerMin)) r = d - 8'(k * SecPerMin);
    end
    return r[5:0];
  endfunction

  function automatic logic [4:0] mod24(input logic [7:0] d);
    logic [7:0] r;
    r = d;
    for (int k = 1; k <= 10; k++) begin
      if (d >= 8'(k * HourPerDay)) r = d - 8'(k * HourPerDay);
    end
    return r[4:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/crtc_if.sv]
// Interfaces: command and read-data channels of the RTC.
`default_nettype none

interface crtc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [3:0] reg_select;
  logic [7:0] write_data;

  modport source (output valid, output cmd, output reg_select, output write_data, input ready);
  modport sink   (input valid, input cmd, input reg_select, input write_data, output ready);
endinterface

interface crtc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, output read_data, input ready);
  modport sink   (input valid, input read_data, output ready);
endinterface

`default_nettype wire

[hw/rtl/cartridge_rtc_elapsed_seconds.sv]
// Top level: cartridge real-time clock held as days, hours, minutes and seconds of a 32-bit count.
//
//   channel  dir  payload                          handshake
//   in_i     in   cmd, reg_select, write_data      valid/ready
//   out_o    out  read_data                        valid/ready
//
// One item per cycle unless out_o stalls; the result is in the output register the next cycle.
// The count is held in mixed radix, so reads are bit selects and writes a one-step wrap fix.
// Reset clears the count and empties the output register.
// A stalled output register holds; in_i.ready is low only while it is full and not taken.
`default_nettype none

module cartridge_rtc_elapsed_seconds (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  crtc_in_if.sink   in_i,
  crtc_out_if.source out_o
);

  crtc_pkg::rtc_time_t state_q, state_d, raw;
  logic [7:0] rd_d, rd_q;
  logic       out_valid_q;
  logic       accept;

  logic [6:0] s_t, m_t;
  logic [5:0] h_t;
  logic       bs, bm, bh;

  assign in_i.ready      = !out_valid_q || out_o.ready;
  assign accept          = in_i.valid && in_i.ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = rd_q;

  always_comb begin
    raw  = state_q;
    rd_d = '0;
    unique case (crtc_pkg::cmd_e'(in_i.cmd))
      crtc_pkg::CMD_TICK: begin
        if (state_q.secs == 6'(crtc_pkg::SecPerMin - 1)) begin
          raw.secs = '0;
          if (state_q.mins == 6'(crtc_pkg::MinPerHour - 1)) begin
            raw.mins = '0;
            if (state_q.hours == 5'(crtc_pkg::HourPerDay - 1)) begin
              raw.hours = '0;
              raw.days  = state_q.days + 16'd1;
            end else begin
              raw.hours = state_q.hours + 5'd1;
            end
          end else begin
            raw.mins = state_q.mins + 6'd1;
          end
        end else begin
          raw.secs = state_q.secs + 6'd1;
        end
      end
      crtc_pkg::CMD_READ: begin
        unique case (in_i.reg_select)
          crtc_pkg::REG_SEC:      rd_d = {2'b0, state_q.secs};
          crtc_pkg::REG_MIN:      rd_d = {2'b0, state_q.mins};
          crtc_pkg::REG_HOUR:     rd_d = {3'b0, state_q.hours};
          crtc_pkg::REG_DAY_LOW:  rd_d = state_q.days[7:0];
          crtc_pkg::REG_DAY_HIGH: rd_d = {7'b0, state_q.days[8]};
          default:                rd_d = '0;
        endcase
      end
      crtc_pkg::CMD_WRITE: begin
        unique case (in_i.reg_select)
          crtc_pkg::REG_SEC:      raw.secs  = crtc_pkg::mod60(in_i.write_data);
          crtc_pkg::REG_MIN:      raw.mins  = crtc_pkg::mod60(in_i.write_data);
          crtc_pkg::REG_HOUR:     raw.hours = crtc_pkg::mod24(in_i.write_data);
          crtc_pkg::REG_DAY_LOW:  raw.days  = {state_q.days[15:8], in_i.write_data};
          crtc_pkg::REG_DAY_HIGH: raw.days  = {7'b0, in_i.write_data[0], state_q.days[7:0]};
          default:                raw       = state_q;
        endcase
      end
      default: raw = state_q;
    endcase
  end

  // wrap past 2^32: subtract WrapTime digit by digit
  always_comb begin
    s_t = {1'b0, raw.secs} - {1'b0, crtc_pkg::WrapTime.secs};
    bs  = s_t[6];
    if (bs) s_t = s_t + 7'(crtc_pkg::SecPerMin);
    m_t = {1'b0, raw.mins} - {1'b0, crtc_pkg::WrapTime.mins} - {6'b0, bs};
    bm  = m_t[6];
    if (bm) m_t = m_t + 7'(crtc_pkg::MinPerHour);
    h_t = {1'b0, raw.hours} - {1'b0, crtc_pkg::WrapTime.hours} - {5'b0, bm};
    bh  = h_t[5];
    if (bh) h_t = h_t + 6'(crtc_pkg::HourPerDay);
    state_d = raw;
    if (raw >= crtc_pkg::WrapTime) begin
      state_d.secs  = s_t[5:0];
      state_d.mins  = m_t[5:0];
      state_d.hours = h_t[4:0];
      state_d.days  = raw.days - crtc_pkg::WrapTime.days - {15'b0, bh};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) rd_q <= rd_d;
  end

  a_digits_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.secs < 6'(crtc_pkg::SecPerMin) && state_q.mins < 6'(crtc_pkg::MinPerHour)
    && state_q.hours < 5'(crtc_pkg::HourPerDay))
    else $error("time digit out of range");

  a_below_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q < crtc_pkg::WrapTime)
    else $error("count at or above 2^32");

  a_non_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_i.cmd != crtc_pkg::CMD_READ) |=> out_o.valid && (out_o.read_data == 8'd0))
    else $error("non-read item returned nonzero data");

  a_read_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_i.cmd == crtc_pkg::CMD_READ) |=> $stable(state_q))
    else $error("read changed the count");

endmodule

`default_nettype wire
